// ===== rtl/rbb_pkg.sv =====
// rbb_pkg: shared types and constants of the rgb 3x3 box blur
// no dependencies; imported by every rbb module and by rgb_box_blur_3x3
package rbb_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COL_W        = 11;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned WIDTH_REG_W  = 12;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned REG_IDX_W    = 1;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd1000;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd500;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX   = 13'd4096;
  localparam int unsigned             SIZE_MIN     = 3;

  // nine values of 8 bits sum to at most 2295
  localparam int unsigned WIN_TAPS   = 9;
  localparam int unsigned SUM_W      = 12;
  // floor(x / 9) == (x * 7282) >> 16 for every x below 2296
  localparam int unsigned RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rbb_pix_t;

  localparam int unsigned PIX_BITS = $bits(rbb_pix_t);

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } rbb_sum_t;

  // position info that travels with a pixel
  typedef struct packed {
    logic             emit;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             frame_end;
  } rbb_meta_t;

endpackage

// ===== rtl/rbb_pos_ctrl.sv =====
// rbb_pos_ctrl: frame size registers and raster position counters
// depends on rbb_pkg
module rbb_pos_ctrl
  import rbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [REG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    advance_i,
  output logic [CW-1:0]           col_o,
  output rbb_meta_t               meta_o
);

  localparam int unsigned WW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [CW-1:0]           col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;

  logic [WW-1:0]           w_eff, width_ext, col_ext, col_inc, col_dec;
  logic [HEIGHT_REG_W-1:0] h_eff, row_ext, row_inc;

  always_comb begin
    width_ext = WW'(width_q);
    if (width_ext < WW'(SIZE_MIN)) begin
      w_eff = WW'(SIZE_MIN);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    if (height_q < HEIGHT_REG_W'(SIZE_MIN)) begin
      h_eff = HEIGHT_REG_W'(SIZE_MIN);
    end else if (height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = height_q;
    end
  end

  assign col_ext = WW'(col_q);
  assign col_inc = col_ext + WW'(1);
  assign col_dec = col_ext - WW'(1);
  assign row_ext = HEIGHT_REG_W'(row_q);
  assign row_inc = row_ext + HEIGHT_REG_W'(1);

  // wrap when the next position would reach the frame size
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (advance_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  assign col_o            = col_q;
  assign meta_o.emit      = (col_ext >= WW'(2)) && (row_q >= ROW_W'(2));
  assign meta_o.column    = col_dec[COL_W-1:0];
  assign meta_o.row       = row_q - ROW_W'(1);
  assign meta_o.frame_end = (col_ext == w_eff - WW'(1)) &&
                            (row_ext == h_eff - HEIGHT_REG_W'(1));

endmodule

// ===== rtl/rbb_line_store.sv =====
// rbb_line_store: line buffer ram, one write and one registered read port
// depends on rbb_pkg
module rbb_line_store
  import rbb_pkg::*;
#(
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned DW = 2 * PIX_BITS
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/rbb_window.sv =====
// rbb_window: 3x3 pixel window and per-channel nine-value sums
// depends on rbb_pkg
module rbb_window
  import rbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rbb_pix_t  above2_i,
  input  rbb_pix_t  above1_i,
  input  rbb_pix_t  pix_i,
  input  rbb_meta_t meta_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rbb_sum_t  sum_o,
  output rbb_meta_t meta_o
);

  // rows: 0 two above, 1 one above, 2 current; column 2 is newest
  rbb_pix_t  win_q [WIN_TAPS];
  logic      win_valid_q;
  rbb_meta_t win_meta_q;
  rbb_sum_t  sum_q, sum_d;
  rbb_meta_t sum_meta_q;
  logic      sum_valid_q;

  logic sum_ready, win_adv, in_acc;

  assign sum_ready  = !sum_valid_q || out_ready_i;
  assign win_adv    = win_valid_q && sum_ready;
  assign in_ready_o = !win_valid_q || sum_ready;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WIN_TAPS; i++) begin
      sum_d.red   = sum_d.red   + SUM_W'(win_q[i].red);
      sum_d.green = sum_d.green + SUM_W'(win_q[i].green);
      sum_d.blue  = sum_d.blue  + SUM_W'(win_q[i].blue);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        win_q[i] <= '0;
      end
      win_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      // every pixel shifts the window, only interior ones go on
      if (in_acc) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2]    <= above2_i;
        win_q[5]    <= above1_i;
        win_q[8]    <= pix_i;
        win_valid_q <= meta_i.emit;
      end else if (win_adv) begin
        win_valid_q <= 1'b0;
      end
      if (win_adv) begin
        sum_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        sum_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      win_meta_q <= meta_i;
    end
    if (win_adv) begin
      sum_q      <= sum_d;
      sum_meta_q <= win_meta_q;
    end
  end

  assign out_valid_o = sum_valid_q;
  assign sum_o       = sum_q;
  assign meta_o      = sum_meta_q;

endmodule

// ===== rtl/rbb_mean.sv =====
// rbb_mean: divides channel sums by nine and holds the result register
// depends on rbb_pkg
module rbb_mean
  import rbb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rbb_sum_t         sum_i,
  input  rbb_meta_t        meta_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rbb_pix_t         mean_o,
  output rbb_meta_t        meta_o
);

  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  rbb_pix_t          mean_q, mean_d;
  rbb_meta_t         meta_q;
  logic              valid_q;
  logic              in_acc;

  assign in_ready_o = !valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // multiply by the reciprocal of nine
  assign prod_r = PROD_W'(sum_i.red)   * PROD_W'(DIV9_RECIP);
  assign prod_g = PROD_W'(sum_i.green) * PROD_W'(DIV9_RECIP);
  assign prod_b = PROD_W'(sum_i.blue)  * PROD_W'(DIV9_RECIP);

  assign mean_d.red   = prod_r[DIV9_SHIFT +: PIX_W];
  assign mean_d.green = prod_g[DIV9_SHIFT +: PIX_W];
  assign mean_d.blue  = prod_b[DIV9_SHIFT +: PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_acc) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mean_q <= mean_d;
      meta_q <= meta_i;
    end
  end

  assign out_valid_o = valid_q;
  assign mean_o      = mean_q;
  assign meta_o      = meta_q;

endmodule

// ===== rtl/rgb_box_blur_3x3.sv =====
// rgb_box_blur_3x3: streaming 3x3 box blur on rgb pixels in raster order
// depends on rbb_pkg, rbb_pos_ctrl, rbb_line_store, rbb_window, rbb_mean
//
// channel   direction  payload
// s_axis    in         pixel: red, green, blue
// m_axis    out        mean red, green, blue, column, row; tlast marks frame end
// cfg       in         write of image_width (index 0) or image_height (index 1)
//
// one pixel accepted per clock unless m_axis_tready back-pressure stalls the stages
// pixel -> line store read -> window -> sums -> divide-by-nine result register
// the line store ram has one read and one write port, both used every pixel
// border pixels only update the line store and window and make no request
// reset clears counters, window and valid flags; line store contents are not cleared
// each stage holds its request while the next one is full, so stalls back up in order
module rgb_box_blur_3x3
  import rbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // red, green, blue
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // red, green, blue, column, row, zero pad
  output logic                  m_axis_tlast,   // frame_end
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned PAD_W = 48 - 3 * PIX_W - COL_W - ROW_W;

  logic              s_acc;
  logic [CW-1:0]     cur_col;
  rbb_meta_t         cur_meta;

  logic              s1_valid_q;
  rbb_pix_t          s1_pix_q;
  rbb_meta_t         s1_meta_q;
  logic [CW-1:0]     s1_col_q;
  logic              s1_adv;
  logic [2*PIX_BITS-1:0] ls_rd_data;
  rbb_pix_t          above2, above1;

  logic              win_in_ready, win_out_valid, mean_in_ready;
  rbb_sum_t          win_sum;
  rbb_meta_t         win_meta;
  rbb_pix_t          mean_pix;
  rbb_meta_t         mean_meta;

  assign s_axis_tready = !s1_valid_q || win_in_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_valid_q && win_in_ready;

  rbb_pos_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (s_acc),
    .col_o       (cur_col),
    .meta_o      (cur_meta)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_pix_q.red   <= s_axis_tdata[7:0];
      s1_pix_q.green <= s_axis_tdata[15:8];
      s1_pix_q.blue  <= s_axis_tdata[23:16];
      s1_meta_q      <= cur_meta;
      s1_col_q       <= cur_col;
    end
  end

  // entry holds {two rows above, one row above}; rows age by one on write
  rbb_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (s_acc),
    .rd_addr_i (cur_col),
    .rd_data_o (ls_rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({above1, s1_pix_q})
  );

  assign above2 = ls_rd_data[2*PIX_BITS-1:PIX_BITS];
  assign above1 = ls_rd_data[PIX_BITS-1:0];

  rbb_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (win_in_ready),
    .above2_i    (above2),
    .above1_i    (above1),
    .pix_i       (s1_pix_q),
    .meta_i      (s1_meta_q),
    .out_valid_o (win_out_valid),
    .out_ready_i (mean_in_ready),
    .sum_o       (win_sum),
    .meta_o      (win_meta)
  );

  rbb_mean u_mean (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (win_out_valid),
    .in_ready_o  (mean_in_ready),
    .sum_i       (win_sum),
    .meta_i      (win_meta),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mean_o      (mean_pix),
    .meta_o      (mean_meta)
  );

  assign m_axis_tdata = {PAD_W'(0), mean_meta.row, mean_meta.column,
                         mean_pix.blue, mean_pix.green, mean_pix.red};
  assign m_axis_tlast = mean_meta.frame_end;

endmodule
